// ----- hw/rtl/rlf_pkg.sv -----
package rlf_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned RING_LEN  = 17;
	localparam int unsigned PTR_W     = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PTR_W-1:0]  ptr_t;

	localparam ptr_t  RING_TOP  = 5'd16;
	localparam ptr_t  LAG_START = 5'd10;
	localparam word_t LCG_MUL   = 32'd2891336453;
	localparam word_t SUB_RESET = 32'd1;

	// request codes
	typedef enum logic {
		OP_DRAW = 1'b0,
		OP_SEED = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_SEED
	} state_t;

	// rotate left by 13
	function automatic word_t rotl_lag(input word_t w);
		return {w[18:0], w[31:19]};
	endfunction

	// rotate left by 9
	function automatic word_t rotl_own(input word_t w);
		return {w[22:0], w[31:23]};
	endfunction

	// step a ring pointer down, wrapping to the top
	function automatic ptr_t step_down(input ptr_t p);
		return (p == '0) ? RING_TOP : ptr_t'(p - 5'd1);
	endfunction

endpackage

// ----- hw/rtl/rlf_if.sv -----
interface rlf_req_if;
	logic                valid;
	logic                ready;
	logic                op;
	rlf_pkg::word_t      seed_value;

	modport source (output valid, output op, output seed_value, input ready);
	modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface rlf_rsp_if;
	logic                valid;
	logic                ready;
	rlf_pkg::word_t      random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

// ----- hw/rtl/rlf_ram.sv -----
module rlf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/rotating_lagged_fibonacci_rng.sv -----
// Rotate-and-add lagged Fibonacci generator over a ring of 17 words.
// Request channel (req): op = 0 draws the next word, op = 1 reseeds the ring
// from seed_value; a zero seed is replaced by the value last written on the
// configuration port (cfg_we / cfg_wdata, 1 after reset).
// Response channel (rsp): one random_word beat for each draw, none for a seed.
// A draw reads the ring from two copies of the ring memory in the cycle after
// the request beat, and the sum is written back and placed in the output
// register at the end of that cycle unless the output is stalled. A reseed
// holds the request channel for the request beat and then while the single
// multiplier steps the LCG once for each of the 17 ring writes. One item is
// in work at a time.
// Reset clears the pointers (write 0, lag 10) and the per-entry valid bits, so
// the ring reads as zeros and draws return 0 until the first reseed.
// If the receiver stalls with a word held in the output register, a finished
// draw waits in its read cycle and no further request is taken.
module rotating_lagged_fibonacci_rng (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  rlf_pkg::word_t   cfg_wdata,
	rlf_req_if.sink          req,
	rlf_rsp_if.source        rsp
);

	rlf_pkg::state_t state_q, state_d;
	rlf_pkg::ptr_t   wp_q, lp_q, cnt_q;
	rlf_pkg::word_t  sub_q, lcg_q, out_word_q;
	logic            out_valid_q;
	logic [rlf_pkg::RING_LEN-1:0] valid_q;

	rlf_pkg::word_t  own_rd, lag_rd, own_word, lag_word, sum_word;
	rlf_pkg::word_t  lcg_prod, lcg_next, wdata;
	rlf_pkg::ptr_t   waddr;
	logic            we, accept, draw_done, seed_last;
	rlf_pkg::word_t  seed_start;

	// two copies of the ring: one read at the write pointer, one at the lag
	rlf_ram #(.WIDTH(rlf_pkg::WORD_W), .DEPTH(rlf_pkg::RING_LEN)) u_ram_own (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (wp_q),
		.rdata (own_rd)
	);

	rlf_ram #(.WIDTH(rlf_pkg::WORD_W), .DEPTH(rlf_pkg::RING_LEN)) u_ram_lag (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (lp_q),
		.rdata (lag_rd)
	);

	// unwritten entries read as zero
	assign own_word = valid_q[wp_q] ? own_rd : '0;
	assign lag_word = valid_q[lp_q] ? lag_rd : '0;
	assign sum_word = rlf_pkg::word_t'(rlf_pkg::rotl_lag(lag_word) +
		rlf_pkg::rotl_own(own_word));

	// LCG step
	assign lcg_prod   = rlf_pkg::word_t'(lcg_q * rlf_pkg::LCG_MUL);
	assign lcg_next   = rlf_pkg::word_t'(lcg_prod + 32'd1);
	assign seed_start = (req.seed_value == '0) ? sub_q : req.seed_value;

	assign accept    = req.valid && req.ready;
	assign draw_done = (state_q == rlf_pkg::ST_DRAW) && (!out_valid_q || rsp.ready);
	assign seed_last = (state_q == rlf_pkg::ST_SEED) && (cnt_q == rlf_pkg::RING_TOP);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.op == rlf_pkg::OP_SEED) ? rlf_pkg::ST_SEED
						: rlf_pkg::ST_DRAW;
				end
			end
			rlf_pkg::ST_DRAW: begin
				if (draw_done) begin
					state_d = rlf_pkg::ST_IDLE;
				end
			end
			rlf_pkg::ST_SEED: begin
				if (seed_last) begin
					state_d = rlf_pkg::ST_IDLE;
				end
			end
			default: state_d = rlf_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		we        = 1'b0;
		waddr     = wp_q;
		wdata     = sum_word;
		unique case (state_q)
			rlf_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			rlf_pkg::ST_DRAW: begin
				we = draw_done;
			end
			rlf_pkg::ST_SEED: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = lcg_next;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// hold the zero-seed substitute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= rlf_pkg::SUB_RESET;
		end else if (cfg_we) begin
			sub_q <= cfg_wdata;
		end
	end

	// sequencer, pointers, valid bits, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlf_pkg::ST_IDLE;
			wp_q        <= '0;
			lp_q        <= rlf_pkg::LAG_START;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (accept && req.op == rlf_pkg::OP_SEED) begin
				cnt_q <= '0;
			end else if (state_q == rlf_pkg::ST_SEED) begin
				cnt_q <= rlf_pkg::ptr_t'(cnt_q + 5'd1);
			end
			if (seed_last) begin
				wp_q <= '0;
				lp_q <= rlf_pkg::LAG_START;
			end else if (draw_done) begin
				wp_q <= rlf_pkg::step_down(wp_q);
				lp_q <= rlf_pkg::step_down(lp_q);
			end
			if (draw_done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: LCG state and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			lcg_q <= seed_start;
		end else if (state_q == rlf_pkg::ST_SEED) begin
			lcg_q <= lcg_next;
		end
		if (draw_done) begin
			out_word_q <= sum_word;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_word_q;

	// pointers keep a fixed lag of 10 around the ring
	a_lag_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q < 5'd7) ? (lp_q == wp_q + 5'd10) : (lp_q == wp_q - 5'd7))
		else $error("lag pointer lost its distance from write pointer");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= rlf_pkg::RING_TOP && lp_q <= rlf_pkg::RING_TOP)
		else $error("ring pointer out of range");

	a_seed_fills: assert property (@(posedge clk) disable iff (!arst_n)
		seed_last |=> (&valid_q))
		else $error("reseed left ring entries unwritten");

	a_draw_beat: assert property (@(posedge clk) disable iff (!arst_n)
		draw_done |=> rsp.valid)
		else $error("finished draw gave no output beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(out_word_q))
		else $error("stalled output word overwritten");

endmodule

// ----- test/rlf_monitor.sv -----
`timescale 1ns / 100ps

module rlf_monitor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  rlf_pkg::word_t cfg_wdata,
	rlf_req_if             req,
	rlf_rsp_if             rsp,
	output int unsigned    mismatches,
	output int unsigned    waiting
);

	// shadow copy of the generator state
	rlf_pkg::word_t ring [0:rlf_pkg::RING_LEN-1];
	rlf_pkg::ptr_t  wr_ptr;
	rlf_pkg::ptr_t  lag_ptr;
	rlf_pkg::word_t zero_sub;
	rlf_pkg::word_t pending_words [$];

	function automatic rlf_pkg::word_t spin(input rlf_pkg::word_t w, input int unsigned k);
		return (w << k) | (w >> (rlf_pkg::WORD_W - k));
	endfunction

	function automatic rlf_pkg::ptr_t ring_prev(input rlf_pkg::ptr_t p);
		return (p == rlf_pkg::ptr_t'(0)) ? rlf_pkg::ptr_t'(rlf_pkg::RING_LEN - 1)
			: rlf_pkg::ptr_t'(p - 1);
	endfunction

	// refill the ring from the LCG and rewind both pointers
	function automatic void fill_ring(input rlf_pkg::word_t seed);
		rlf_pkg::word_t s;
		s = (seed == '0) ? zero_sub : seed;
		for (int i = 0; i < rlf_pkg::RING_LEN; i++) begin
			s = s * rlf_pkg::LCG_MUL + rlf_pkg::word_t'(1);
			ring[i] = s;
		end
		wr_ptr  = '0;
		lag_ptr = rlf_pkg::LAG_START;
	endfunction

	// rotate-and-add, write back at the own slot, step both pointers down
	function automatic rlf_pkg::word_t next_word();
		rlf_pkg::word_t sum;
		sum = spin(ring[lag_ptr], 13) + spin(ring[wr_ptr], 9);
		ring[wr_ptr] = sum;
		wr_ptr  = ring_prev(wr_ptr);
		lag_ptr = ring_prev(lag_ptr);
		return sum;
	endfunction

	task automatic flag(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rlf_pkg::word_t want;
		if (!arst_n) begin
			foreach (ring[i])
				ring[i] = '0;
			wr_ptr   = '0;
			lag_ptr  = rlf_pkg::LAG_START;
			zero_sub = rlf_pkg::SUB_RESET;
			pending_words.delete();
			waiting  = 0;
		end else begin
			// track the substitute seed register
			if (cfg_we)
				zero_sub = cfg_wdata;

			// check a response beat against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (pending_words.size() == 0) begin
					flag($sformatf("word %08h with no draw outstanding", rsp.random_word));
				end else begin
					want = pending_words.pop_front();
					if (rsp.random_word !== want)
						flag($sformatf("random_word %08h, predicted %08h",
							rsp.random_word, want));
				end
			end

			// advance the shadow state on each request beat
			if (req.valid && req.ready) begin
				if (req.op == rlf_pkg::OP_SEED)
					fill_ring(req.seed_value);
				else
					pending_words.push_back(next_word());
			end
			waiting = pending_words.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned SETTLE           = 25;
	localparam int unsigned RANDOM_PER_PHASE = 330;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	rlf_pkg::word_t cfg_wdata;
	bit             calm;
	int unsigned    mismatches;
	int unsigned    waiting;
	rlf_pkg::word_t subs [4];

	rlf_req_if req_ch ();
	rlf_rsp_if rsp_ch ();

	rotating_lagged_fibonacci_rng dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	rlf_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 29);
	endfunction

	// receiver stalls at random
	always @(negedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(99) >= 29);
	end

	// offer one request beat and hold it until taken
	task automatic send_item(input rlf_pkg::op_t o, input rlf_pkg::word_t s);
		@(negedge clk);
		while (take_break()) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= o;
		req_ch.seed_value <= s;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// drop valid and hold until every predicted word has come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	// write the register only once the block has gone quiet
	task automatic set_substitute(input rlf_pkg::word_t v);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_item();
		if ($urandom_range(99) < 6)
			send_item(rlf_pkg::OP_SEED, ($urandom_range(3) == 0) ? rlf_pkg::word_t'(0)
				: rlf_pkg::word_t'($urandom()));
		else
			send_item(rlf_pkg::OP_DRAW, $urandom());
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		calm              = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = rlf_pkg::OP_DRAW;
		req_ch.seed_value = '0;
		rsp_ch.ready      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// draws on the unseeded ring, then a zero seed with the reset substitute
		send_item(rlf_pkg::OP_DRAW, 32'hFFFF_FFFF);
		send_item(rlf_pkg::OP_DRAW, 32'h0);
		send_item(rlf_pkg::OP_SEED, 32'h0);
		// run both pointers through their wrap
		repeat (17) send_item(rlf_pkg::OP_DRAW, $urandom());
		send_item(rlf_pkg::OP_SEED, 32'hFFFF_FFFF);
		send_item(rlf_pkg::OP_DRAW, 32'h0);
		send_item(rlf_pkg::OP_DRAW, 32'hFFFF_FFFF);

		subs[0] = 32'h0;
		subs[1] = 32'hFFFF_FFFF;
		subs[2] = $urandom();
		subs[3] = rlf_pkg::SUB_RESET;
		for (int k = 0; k < 4; k++) begin
			set_substitute(subs[k]);
			send_item(rlf_pkg::OP_SEED, 32'h0);
			send_item(rlf_pkg::OP_DRAW, $urandom());
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (k == 0 && n == 160)
					drain();
				calm = (k == 2) && (n >= 100) && (n < 250);
				random_item();
			end
			calm = 1'b0;
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/rlf_pkg.sv
hw/rtl/rlf_if.sv
hw/rtl/rlf_ram.sv
hw/rtl/rotating_lagged_fibonacci_rng.sv
test/rlf_monitor.sv
test/testbench.sv
